// ----- rtl/core/ihn_pkg.sv -----
// Shared types and constants of the intensity histogram normalizer.
`default_nettype none

package ihn_pkg;

   // Fixed field widths of the request, response and CSR beats.
   localparam int OP_W       = 2;
   localparam int SAMPLE_W   = 8;
   localparam int SCALE_W    = 12;
   localparam int FLOOR_W    = 8;
   localparam int HEIGHT_W   = 12;
   localparam int OUT_CNT_W  = 24;
   localparam int CSR_IDX_W  = 1;
   localparam int DIV_STEP_W = 4;

   typedef logic [OP_W-1:0]      op_type;
   typedef logic [CSR_IDX_W-1:0] csr_index_type;

   // Operation codes carried in req_tuser.
   localparam op_type OP_CLEAR = 2'd0;
   localparam op_type OP_ADD   = 2'd1;
   localparam op_type OP_READ  = 2'd2;

   // Register indexes of the CSR write port.
   localparam csr_index_type CSR_BAR_SCALE = 1'b0;
   localparam csr_index_type CSR_IGNORED   = 1'b1;

   // Reset values of the registers.
   localparam logic [SCALE_W-1:0] BAR_SCALE_RESET = 12'd280;
   localparam logic [FLOOR_W-1:0] IGNORED_RESET   = 8'd1;

endpackage

`default_nettype wire

// ----- rtl/core/intensity_histogram_normalizer.sv -----
// Histogram of voxel intensities with bar heights normalized to the peak bin.
//
// The req channel carries one operation per beat: clear, add a sample, or read
// one bin. Only a read produces a beat on the rsp channel, holding the bin's
// normalized height, its raw count and the running peak. The user must use the
// csr port to write bar_scale and ignored_low_bins only while the block is idle;
// the block itself does not enforce this.
// The counts live in one synchronous single-port-read memory. In an add, the
// bin is read in the accept cycle and written back, incremented and saturated,
// in the next; req_tready returns the cycle after. A read passes through the
// memory read, one 24x12 multiply, a divider setup step, then a restoring
// divider that retires one quotient bit per cycle until all 12 quotient bits
// are formed, and a final load into the response register. A clear sweeps the
// memory one bin per cycle and keeps req_tready low until the sweep ends; the
// same sweep runs right after reset. The response sits in an output register,
// so a stalled rsp side only holds up the next read when its result is ready
// to leave; adds and clears keep being accepted while a response waits.
`default_nettype none

module intensity_histogram_normalizer #(
   parameter int NUM_BINS   = 256,
   parameter int COUNT_BITS = 24
) (
   input  wire logic        clock,
   input  wire logic        reset,
   // Request channel.
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [15:0] req_tdata,   // [7:0] sample, [15:8] bin_index
   input  wire logic [1:0]  req_tuser,   // [1:0] op
   // Response channel.
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [63:0]      rsp_tdata,   // [11:0] height, [35:12] raw_count,
                                         // [59:36] peak_count, [63:60] zero
   // CSR write port.
   input  wire logic        csr_we,
   input  wire logic        csr_index,
   input  wire logic [11:0] csr_wdata
);

   localparam int IDX_W  = (NUM_BINS > 1) ? $clog2(NUM_BINS) : 1;
   localparam int PROD_W = COUNT_BITS + ihn_pkg::HEIGHT_W;
   localparam int HW     = ihn_pkg::HEIGHT_W;
   localparam int STEP_W = ihn_pkg::DIV_STEP_W;
   localparam int OUT_W  = ihn_pkg::OUT_CNT_W;

   typedef enum logic [2:0] {
      S_CLEAR,
      S_IDLE,
      S_ADD,
      S_READ,
      S_LOAD,
      S_DIV,
      S_DONE
   } state_type;

   state_type                         state_ff, state_in;
   logic [IDX_W-1:0]                  sweep_ff, sweep_in;
   logic [COUNT_BITS-1:0]             peak_ff, peak_in;
   logic [IDX_W-1:0]                  addr_ff, addr_in;
   logic                              counted_ff, counted_in;
   logic [COUNT_BITS-1:0]             count_ff, count_in;
   logic [PROD_W-1:0]                 prod_ff, prod_in;
   logic [COUNT_BITS-1:0]             rem_ff, rem_in;
   logic [HW-1:0]                     low_ff, low_in;
   logic [HW-1:0]                     quo_ff, quo_in;
   logic [STEP_W-1:0]                 step_ff, step_in;
   logic                              rsp_valid_ff, rsp_valid_in;
   logic [63:0]                       rsp_data_ff, rsp_data_in;
   logic [ihn_pkg::SCALE_W-1:0]       scale_ff, scale_in;
   logic [ihn_pkg::FLOOR_W-1:0]       floor_ff, floor_in;

   // Count memory.
   logic [COUNT_BITS-1:0]             mem [NUM_BINS];
   logic [COUNT_BITS-1:0]             rd_data_ff;
   logic [IDX_W-1:0]                  mem_raddr;
   logic                              mem_we;
   logic [IDX_W-1:0]                  mem_waddr;
   logic [COUNT_BITS-1:0]             mem_wdata;

   ihn_pkg::op_type                   req_op;
   logic [ihn_pkg::SAMPLE_W-1:0]      req_sample;
   logic [ihn_pkg::SAMPLE_W-1:0]      req_bin;
   logic [ihn_pkg::SAMPLE_W-1:0]      sel_bin;
   logic                              sel_counted;
   logic                              req_fire;
   logic [COUNT_BITS-1:0]             add_wdata;
   logic [COUNT_BITS:0]               trial;
   logic                              trial_ge;
   logic [HW-1:0]                     height;

   assign req_op     = req_tuser;
   assign req_sample = req_tdata[7:0];
   assign req_bin    = req_tdata[15:8];
   assign req_tready = (state_ff == S_IDLE);
   assign req_fire   = req_tvalid && req_tready;

   // An add addresses the sample's bin, a read the requested bin.
   assign sel_bin     = (req_op == ihn_pkg::OP_ADD) ? req_sample : req_bin;
   assign sel_counted = (32'(sel_bin) < 32'(NUM_BINS)) && (sel_bin >= floor_ff);
   assign mem_raddr   = IDX_W'(sel_bin);

   // Saturating increment of the bin read back from memory.
   assign add_wdata = (rd_data_ff == '1) ? rd_data_ff : rd_data_ff + 1'b1;

   assign mem_we    = (state_ff == S_CLEAR) || ((state_ff == S_ADD) && counted_ff);
   assign mem_waddr = (state_ff == S_CLEAR) ? sweep_ff : addr_ff;
   assign mem_wdata = (state_ff == S_CLEAR) ? '0 : add_wdata;

   // One restoring division step: shift in the next dividend bit and subtract.
   assign trial    = {rem_ff, low_ff[HW-1]};
   assign trial_ge = (trial >= {1'b0, peak_ff});

   // An empty histogram reports height zero instead of the divider output.
   assign height = (peak_ff == '0) ? '0 : quo_ff;

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= mem_wdata;
      end
      rd_data_ff <= mem[mem_raddr];
   end

   always_comb begin
      state_in     = state_ff;
      sweep_in     = sweep_ff;
      peak_in      = peak_ff;
      addr_in      = addr_ff;
      counted_in   = counted_ff;
      count_in     = count_ff;
      prod_in      = prod_ff;
      rem_in       = rem_ff;
      low_in       = low_ff;
      quo_in       = quo_ff;
      step_in      = step_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      scale_in     = scale_ff;
      floor_in     = floor_ff;

      if (csr_we) begin
         case (csr_index)
            ihn_pkg::CSR_BAR_SCALE: scale_in = csr_wdata;
            ihn_pkg::CSR_IGNORED:   floor_in = csr_wdata[ihn_pkg::FLOOR_W-1:0];
            default: ;
         endcase
      end

      case (state_ff)
         S_CLEAR: begin
            sweep_in = sweep_ff + 1'b1;
            if (sweep_ff == IDX_W'(NUM_BINS - 1)) begin
               sweep_in = '0;
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_fire) begin
               addr_in    = mem_raddr;
               counted_in = sel_counted;
               case (req_op)
                  ihn_pkg::OP_CLEAR: begin
                     peak_in  = '0;
                     sweep_in = '0;
                     state_in = S_CLEAR;
                  end
                  ihn_pkg::OP_ADD:  state_in = S_ADD;
                  ihn_pkg::OP_READ: state_in = S_READ;
                  default: ;
               endcase
            end
         end
         S_ADD: begin
            if (counted_ff && (add_wdata > peak_ff)) begin
               peak_in = add_wdata;
            end
            state_in = S_IDLE;
         end
         S_READ: begin
            count_in = counted_ff ? rd_data_ff : '0;
            prod_in  = PROD_W'(count_in) * PROD_W'(scale_ff);
            state_in = S_LOAD;
         end
         S_LOAD: begin
            // The count never exceeds the peak, so the upper part stays below it.
            rem_in   = prod_ff[PROD_W-1:HW];
            low_in   = prod_ff[HW-1:0];
            quo_in   = '0;
            step_in  = STEP_W'(HW - 1);
            state_in = S_DIV;
         end
         S_DIV: begin
            rem_in  = trial_ge ? COUNT_BITS'(trial - {1'b0, peak_ff})
                               : trial[COUNT_BITS-1:0];
            low_in  = {low_ff[HW-2:0], 1'b0};
            quo_in  = {quo_ff[HW-2:0], trial_ge};
            step_in = step_ff - 1'b1;
            if (step_ff == '0) begin
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = {4'b0000,
                               OUT_W'(peak_ff),
                               OUT_W'(count_ff),
                               height};
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         sweep_ff     <= '0;
         peak_ff      <= '0;
         rsp_valid_ff <= 1'b0;
         scale_ff     <= ihn_pkg::BAR_SCALE_RESET;
         floor_ff     <= ihn_pkg::IGNORED_RESET;
      end else begin
         state_ff     <= state_in;
         sweep_ff     <= sweep_in;
         peak_ff      <= peak_in;
         rsp_valid_ff <= rsp_valid_in;
         scale_ff     <= scale_in;
         floor_ff     <= floor_in;
      end
      addr_ff     <= addr_in;
      counted_ff  <= counted_in;
      count_ff    <= count_in;
      prod_ff     <= prod_in;
      rem_ff      <= rem_in;
      low_ff      <= low_in;
      quo_ff      <= quo_in;
      step_ff     <= step_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // The peak always covers the count just written back.
   a_peak_covers_add: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_ADD && counted_ff) |=> (peak_ff >= $past(add_wdata)))
      else $error("running peak below a freshly written count");

   // A normalized height never exceeds the scale it normalizes to.
   a_height_bounded: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DONE) |-> (height <= scale_ff))
      else $error("normalized height above bar_scale");

   // An accepted clear empties the running peak.
   a_clear_peak: assert property (@(posedge clock) disable iff (reset)
      (req_fire && req_op == ihn_pkg::OP_CLEAR) |=> (peak_ff == '0))
      else $error("running peak not cleared");

   // A response beat is only ever loaded at the end of a read.
   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !$past(rsp_valid_ff && !rsp_tready)) |->
         ($past(state_ff) == S_DONE))
      else $error("response loaded outside a read");

endmodule

`default_nettype wire
